>>> rtl/di_pkg.sv
`default_nettype none
package di_pkg;
  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned KEY_BITS_DEF = 16;
  localparam int unsigned ID_W = 11;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_CLEARED  = 2'd2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PART_RD,
    S_PART_CMP,
    S_SIFT_RD,
    S_SIFT_CMP,
    S_VIEW_RD1,
    S_VIEW_RD2,
    S_VIEW_RD3,
    S_VIEW_RD4,
    S_VIEW_DONE,
    S_OUT
  } state_t;
endpackage
`default_nettype wire

>>> rtl/deap_insert.sv
`default_nettype none
// An insert writes its new entry, compares it with its partner, sifts it up on
// its own side and then reads the view; a clear or a rejected insert goes
// straight to the view reads. One item is in flight at a time; the result sits
// in the output registers until taken and the next item can be taken in the
// cycle after the result beat. The state machine sets the rate.
// Reset: synchronous, active high; count 0, next serial 1; memory not cleared.
module deap_insert
  import di_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned KEY_BITS = KEY_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                command,
  input  wire logic [KEY_BITS-1:0] key,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               status,
  output logic [ID_W-1:0]          entry_count,
  output logic [KEY_BITS-1:0]      min_key,
  output logic [ID_W-1:0]          min_id,
  output logic [KEY_BITS-1:0]      max_key,
  output logic [ID_W-1:0]          max_id,
  output logic [KEY_BITS-1:0]      bottom_key,
  output logic [ID_W-1:0]          bottom_id,
  output logic [KEY_BITS-1:0]      leftmost_key,
  output logic [ID_W-1:0]          leftmost_id
);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned PW = $clog2(CAPACITY + 2) + 1;
  localparam int unsigned EW = KEY_BITS + ID_W;

  logic [EW-1:0] mem [CAPACITY];

  state_t state, state_next;
  logic [PW-1:0] count, p, q;
  logic [ID_W-1:0] serial;
  logic side_max;
  logic [EW-1:0] ent_p, rd_data;
  logic [1:0] st;

  logic rd_en, wr_en;
  logic [PW-1:0] rd_pos, wr_pos;
  logic [EW-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[AW'(wr_pos - PW'(1))] <= wr_data;
    if (rd_en) rd_data <= mem[AW'(rd_pos - PW'(1))];
  end

  // level helpers
  function automatic logic [PW-1:0] top_pow(input logic [PW-1:0] x);
    logic [PW-1:0] r;
    r = '0;
    for (int i = 0; i < PW; i++) if (x[i]) r = PW'(1) << i;
    return r;
  endfunction

  logic [PW-1:0] np, half, partner, up, lm;
  logic mside;
  always_comb begin
    np = count + PW'(1);
    half = top_pow(np + PW'(1)) >> 1;
    mside = np < (half + (half << 1) - PW'(1));
    if (np == PW'(1)) partner = PW'(1);
    else if (mside) partner = (np + half - PW'(1)) >> 1;
    else partner = np - half;
    up = (p - PW'(1)) >> 1;
    lm = top_pow(count + PW'(1)) - PW'(1);
  end

  wire [KEY_BITS-1:0] kp = ent_p[EW-1:ID_W];
  wire [KEY_BITS-1:0] kr = rd_data[EW-1:ID_W];
  wire viol_part = side_max ? (kr > kp) : (kr < kp);
  wire up_ok = side_max ? (up >= PW'(2)) : (up >= PW'(1));
  wire viol_up = side_max ? (kp > kr) : (kp < kr);
  wire full = count >= PW'(CAPACITY);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) begin
        if (command == CMD_CLEAR || full) state_next = S_VIEW_RD1;
        else state_next = S_PART_RD;
      end
      S_PART_RD: state_next = S_PART_CMP;
      S_PART_CMP: state_next = S_SIFT_RD;
      S_SIFT_RD: state_next = up_ok ? S_SIFT_CMP : S_VIEW_RD1;
      S_SIFT_CMP: state_next = viol_up ? S_SIFT_RD : S_VIEW_RD1;
      S_VIEW_RD1: state_next = S_VIEW_RD2;
      S_VIEW_RD2: state_next = S_VIEW_RD3;
      S_VIEW_RD3: state_next = S_VIEW_RD4;
      S_VIEW_RD4: state_next = S_VIEW_DONE;
      S_VIEW_DONE: state_next = S_OUT;
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rd_en = 1'b0; rd_pos = PW'(1); wr_en = 1'b0; wr_pos = p; wr_data = ent_p;
    in_ready = state == S_IDLE;
    out_valid = state == S_OUT;
    case (state)
      S_IDLE: begin
        wr_pos = np;
        wr_data = {key, serial};
        wr_en = in_valid && command == CMD_INSERT && !full;
      end
      S_PART_RD: begin rd_en = 1'b1; rd_pos = q; end
      S_PART_CMP: if (viol_part) begin
        wr_en = 1'b1; wr_pos = p; wr_data = rd_data;
      end
      S_SIFT_RD: begin
        rd_en = 1'b1; rd_pos = up;
        if (!up_ok) begin
          wr_en = 1'b1; wr_pos = p; wr_data = ent_p;
        end
      end
      S_SIFT_CMP: begin
        wr_en = 1'b1; wr_pos = p; wr_data = viol_up ? rd_data : ent_p;
      end
      S_VIEW_RD1: begin rd_en = 1'b1; rd_pos = PW'(1); end
      S_VIEW_RD2: begin rd_en = 1'b1; rd_pos = (count >= PW'(2)) ? PW'(2) : PW'(1); end
      S_VIEW_RD3: begin rd_en = 1'b1; rd_pos = count; end
      S_VIEW_RD4: begin rd_en = 1'b1; rd_pos = lm; end
      default: ;
    endcase
  end

  wire [EW-1:0] rd_v = (count == '0) ? '0 : rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      serial <= ID_W'(1);
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: if (in_valid) begin
          if (command == CMD_CLEAR) begin
            count <= '0; serial <= ID_W'(1); st <= ST_CLEARED;
          end else if (full) st <= ST_FULL;
          else begin
            count <= np; serial <= serial + ID_W'(1); st <= ST_INSERTED;
            p <= np; q <= partner; ent_p <= {key, serial};
            side_max <= ~mside;
          end
        end
        S_PART_CMP: begin
          side_max <= side_max ^ viol_part;
          if (viol_part) p <= q;
        end
        S_SIFT_CMP: begin
          if (viol_up) begin
            // old parent moved down; our entry goes to parent slot next
            p <= up;
          end
        end
        default: ;
      endcase
      case (state)
        S_VIEW_RD2: begin min_key <= rd_v[EW-1:ID_W]; min_id <= rd_v[ID_W-1:0]; end
        S_VIEW_RD3: begin max_key <= rd_v[EW-1:ID_W]; max_id <= rd_v[ID_W-1:0]; end
        S_VIEW_RD4: begin bottom_key <= rd_v[EW-1:ID_W]; bottom_id <= rd_v[ID_W-1:0]; end
        S_VIEW_DONE: begin
          leftmost_key <= rd_v[EW-1:ID_W]; leftmost_id <= rd_v[ID_W-1:0];
          status <= st; entry_count <= ID_W'(count);
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> test/deap_checker.sv
`timescale 1ns / 1ps
module deap_checker
  import di_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        command,
  input  wire logic [15:0] key,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [1:0]  status,
  input  wire logic [10:0] entry_count,
  input  wire logic [15:0] min_key,
  input  wire logic [10:0] min_id,
  input  wire logic [15:0] max_key,
  input  wire logic [10:0] max_id,
  input  wire logic [15:0] bottom_key,
  input  wire logic [10:0] bottom_id,
  input  wire logic [15:0] leftmost_key,
  input  wire logic [10:0] leftmost_id,
  output int               errors,
  output int               pending,
  output int               n_full,
  output int               n_clear,
  output int               n_ins
);
  typedef struct packed {
    logic [1:0]  st;
    logic [10:0] cnt;
    logic [15:0] mnk;
    logic [10:0] mni;
    logic [15:0] mxk;
    logic [10:0] mxi;
    logic [15:0] btk;
    logic [10:0] bti;
    logic [15:0] lfk;
    logic [10:0] lfi;
  } view_t;

  localparam int CAP = 1024;

  logic [15:0] heap_key [1:CAP];
  logic [10:0] heap_id  [1:CAP];
  int          fill;
  int          serial;
  view_t       views_due [$];

  function automatic int msb(int x);
    int n;
    n = 0;
    while (x > 1) begin
      x = x >> 1;
      n++;
    end
    return n;
  endfunction

  function automatic void swap_at(int a, int b);
    logic [15:0] k;
    logic [10:0] i;
    k = heap_key[a];
    i = heap_id[a];
    heap_key[a] = heap_key[b];
    heap_id[a] = heap_id[b];
    heap_key[b] = k;
    heap_id[b] = i;
  endfunction

  function automatic void sift(int p, bit is_max);
    int up;
    forever begin
      up = (p - 1) / 2;
      if (is_max) begin
        if (up < 2 || !(heap_key[p] > heap_key[up])) break;
      end else begin
        if (up < 1 || !(heap_key[p] < heap_key[up])) break;
      end
      swap_at(p, up);
      p = up;
    end
  endfunction

  function automatic void place(logic [15:0] k);
    int p, half, mate;
    bit lo;
    p = fill + 1;
    heap_key[p] = k;
    heap_id[p] = serial[10:0];
    fill = p;
    serial++;
    half = 1 << (msb(p + 1) - 1);
    lo = p < half * 3 - 1;
    if (p == 1) mate = 1;
    else if (lo) mate = (p + half - 1) / 2;
    else mate = p - half;
    if (lo) begin
      if (heap_key[mate] < heap_key[p]) begin
        swap_at(mate, p);
        sift(mate, 1'b1);
      end else sift(p, 1'b0);
    end else begin
      if (heap_key[mate] > heap_key[p]) begin
        swap_at(mate, p);
        sift(mate, 1'b0);
      end else sift(p, 1'b1);
    end
  endfunction

  function automatic void peek(int p, output logic [15:0] k, output logic [10:0] i);
    if (p >= 1 && p <= fill) begin
      k = heap_key[p];
      i = heap_id[p];
    end else begin
      k = '0;
      i = '0;
    end
  endfunction

  function automatic view_t apply_beat(logic cmd, logic [15:0] k);
    view_t v;
    if (cmd == CMD_CLEAR) begin
      fill = 0;
      serial = 1;
      v.st = ST_CLEARED;
    end else if (fill >= CAP) v.st = ST_FULL;
    else begin
      place(k);
      v.st = ST_INSERTED;
    end
    v.cnt = fill[10:0];
    peek(1, v.mnk, v.mni);
    peek(fill >= 2 ? 2 : 1, v.mxk, v.mxi);
    peek(fill, v.btk, v.bti);
    peek((1 << msb(fill + 1)) - 1, v.lfk, v.lfi);
    return v;
  endfunction

  always @(posedge clk) begin
    view_t e, a;
    if (rst) begin
      fill = 0;
      serial = 1;
      errors <= 0;
      n_full <= 0;
      n_clear <= 0;
      n_ins <= 0;
      views_due.delete();
    end else begin
      if (in_valid && in_ready) begin
        e = apply_beat(command, key);
        views_due = {views_due, e};
        case (e.st)
          ST_FULL:    n_full <= n_full + 1;
          ST_CLEARED: n_clear <= n_clear + 1;
          default:    n_ins <= n_ins + 1;
        endcase
      end
      if (out_valid && out_ready) begin
        a = {status, entry_count, min_key, min_id, max_key, max_id,
             bottom_key, bottom_id, leftmost_key, leftmost_id};
        if (views_due.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result beat %h", a);
        end else begin
          e = views_due.pop_front();
          if (a !== e) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch exp st%0d cnt%0d mn%h/%0d mx%h/%0d bt%h/%0d lf%h/%0d",
                       e.st, e.cnt, e.mnk, e.mni, e.mxk, e.mxi, e.btk, e.bti,
                       e.lfk, e.lfi,
                       "\n         got st%0d cnt%0d mn%h/%0d mx%h/%0d bt%h/%0d lf%h/%0d",
                       a.st, a.cnt, a.mnk, a.mni, a.mxk, a.mxi, a.btk, a.bti,
                       a.lfk, a.lfi);
          end
        end
      end
    end
  end

  assign pending = views_due.size();
endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import di_pkg::*;

  logic        clk, rst;
  logic        in_valid, in_ready, command;
  logic [15:0] key;
  logic        out_valid, out_ready;
  logic [1:0]  status;
  logic [10:0] entry_count, min_id, max_id, bottom_id, leftmost_id;
  logic [15:0] min_key, max_key, bottom_key, leftmost_key;
  int          errors, pending, n_full, n_clear, n_ins;
  int          idle_ticks;
  bit          calm, hold_off;

  deap_insert u_top (.*);

  deap_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1;
    in_valid = 0;
    command = CMD_INSERT;
    key = '0;
    repeat (6) @(posedge clk);
    rst <= 0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_ticks <= 0;
    else idle_ticks <= idle_ticks + 1;
    if (idle_ticks > 20000) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_off) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(99) >= 25);
  end

  task automatic send_beat(logic cmd, logic [15:0] k);
    while (!calm && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    key <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic insert_run(int n, int span);
    for (int i = 0; i < n; i++)
      send_beat(CMD_INSERT, span == 0 ? 16'($urandom) : 16'($urandom_range(span)));
  endtask

  initial begin
    int waited;
    calm = 0;
    hold_off = 0;
    @(negedge rst);
    @(posedge clk);
    send_beat(CMD_INSERT, 16'hFFFF);
    send_beat(CMD_INSERT, 16'h0000);
    send_beat(CMD_INSERT, 16'h8000);
    send_beat(CMD_INSERT, 16'h7FFF);
    send_beat(CMD_INSERT, 16'h0000);
    send_beat(CMD_INSERT, 16'hFFFF);
    send_beat(CMD_INSERT, 16'h5555);
    send_beat(CMD_INSERT, 16'hAAAA);
    send_beat(CMD_CLEAR, 16'h1234);
    send_beat(CMD_CLEAR, 16'hFFFF);
    send_beat(CMD_INSERT, 16'h0042);
    send_beat(CMD_INSERT, 16'h0042);
    send_beat(CMD_INSERT, 16'h0001);
    send_beat(CMD_CLEAR, 16'h0000);

    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      insert_run(20, 0);
    join

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    insert_run(1030, 7);
    for (int i = 0; i < 4; i++) send_beat(CMD_INSERT, 16'($urandom));
    send_beat(CMD_CLEAR, 16'($urandom));

    calm = 1;
    insert_run(40, 0);
    calm = 0;

    for (int r = 0; r < 10; r++) begin
      if (($urandom_range(9)) == 0) send_beat(CMD_CLEAR, 16'($urandom));
      else insert_run($urandom_range(1, 25), $urandom_range(1) ? 0 : 31);
      if (r == 5) begin
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    $display("Covered %0d inserts, %0d full rejects, %0d clears, with a full fill.",
             n_ins, n_full, n_clear);
    if (errors == 0 && pending == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
